>>> rtl/core/atachs_pkg.sv
// Shared types, codes and constants of the ATA CHS/LBA sector addresser.
`default_nettype none
package atachs_pkg;

	localparam int ADDR_W    = 28;
	localparam int LBA_BITS  = 28;
	localparam int CYL_W     = 16;
	localparam int HEAD_W    = 4;
	localparam int GHEAD_W   = 5;
	localparam int SECT_W    = 8;
	localparam int MD_W      = 30;
	localparam int DVS_W     = 13;
	localparam int MPL_W     = 8;
	localparam int CNT_W     = 5;

	localparam logic [ADDR_W-1:0] LBA_MASK = ADDR_W'((64'd1 << LBA_BITS) - 64'd1);

	localparam logic [CNT_W-1:0] MUL_STEPS = CNT_W'(MPL_W);
	localparam logic [CNT_W-1:0] DIV_STEPS = CNT_W'(ADDR_W);

	localparam logic [ADDR_W-1:0]  RST_CAPACITY = 28'd1032192;
	localparam logic [CYL_W-1:0]   RST_CYLS     = 16'd1024;
	localparam logic [GHEAD_W-1:0] RST_HEADS    = 5'd16;
	localparam logic [SECT_W-1:0]  RST_SECTS    = 8'd63;

	typedef enum logic [2:0] {
		OP_LOAD      = 3'd0,
		OP_TRANSLATE = 3'd1,
		OP_ADVANCE   = 3'd2,
		OP_RECAL     = 3'd3,
		OP_SET_GEOM  = 3'd4
	} op_t;

	typedef enum logic [1:0] {
		FAULT_NONE  = 2'd0,
		FAULT_RANGE = 2'd1,
		FAULT_ZERO  = 2'd2
	} fault_t;

	typedef enum logic [1:0] {
		CFG_CAPACITY = 2'd0,
		CFG_CYLS     = 2'd1,
		CFG_HEADS    = 2'd2,
		CFG_SECTS    = 2'd3
	} cfg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL_HEADS,
		ST_MUL_SECTS,
		ST_MUL_DIVISOR,
		ST_DIV
	} state_t;

	typedef enum logic {
		MD_MUL,
		MD_DIV
	} md_op_t;

	typedef struct packed {
		logic             start;
		md_op_t           op;
		logic [MD_W-1:0]  a;
		logic [MD_W-1:0]  addend;
		logic [DVS_W-1:0] b;
	} md_req_t;

	typedef struct packed {
		logic            done;
		logic [MD_W-1:0] result;
	} md_rsp_t;

endpackage
`default_nettype wire

>>> rtl/core/atachs_muldiv.sv
// Bit-serial shift-add multiplier and restoring divider, one bit per cycle.
`default_nettype none
module atachs_muldiv (
	input  wire                 clk,
	input  wire                 arst_n,
	input  atachs_pkg::md_req_t req,
	output atachs_pkg::md_rsp_t rsp
);

	logic                                 busy_q;
	logic                                 done_q;
	atachs_pkg::md_op_t                   op_q;
	logic [atachs_pkg::CNT_W-1:0]         cnt_q;
	logic [atachs_pkg::MD_W-1:0]          acc_q;
	logic [atachs_pkg::MD_W-1:0]          mcand_q;
	logic [atachs_pkg::MPL_W-1:0]         mplier_q;
	logic [atachs_pkg::DVS_W-1:0]         rem_q;
	logic [atachs_pkg::DVS_W-1:0]         dvs_q;

	logic [atachs_pkg::DVS_W:0] rem_sh;
	logic [atachs_pkg::DVS_W:0] rem_sub;
	logic                       ge;

	assign rem_sh  = {rem_q, acc_q[atachs_pkg::ADDR_W-1]};
	assign ge      = rem_sh >= {1'b0, dvs_q};
	assign rem_sub = rem_sh - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= (req.op == atachs_pkg::MD_MUL) ? atachs_pkg::MUL_STEPS - 1'b1
			                                       : atachs_pkg::DIV_STEPS - 1'b1;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			op_q     <= req.op;
			acc_q    <= (req.op == atachs_pkg::MD_MUL) ? req.addend : req.a;
			mcand_q  <= req.a;
			mplier_q <= req.b[atachs_pkg::MPL_W-1:0];
			dvs_q    <= req.b;
			rem_q    <= '0;
		end else if (busy_q) begin
			if (op_q == atachs_pkg::MD_MUL) begin
				if (mplier_q[0])
					acc_q <= acc_q + mcand_q;
				mcand_q  <= {mcand_q[atachs_pkg::MD_W-2:0], 1'b0};
				mplier_q <= {1'b0, mplier_q[atachs_pkg::MPL_W-1:1]};
			end else begin
				rem_q <= ge ? rem_sub[atachs_pkg::DVS_W-1:0] : rem_sh[atachs_pkg::DVS_W-1:0];
				acc_q <= {(atachs_pkg::MD_W - atachs_pkg::ADDR_W)'(0),
				          acc_q[atachs_pkg::ADDR_W-2:0], ge};
			end
		end
	end

	assign rsp.done   = done_q;
	assign rsp.result = acc_q;

endmodule
`default_nettype wire

>>> rtl/core/ata_chs_lba_sector_addresser.sv
// ATA task-file sector addresser: address state, geometry and translation.
// Load, advance, recalibrate, LBA translate, faulting ops: done on accept.
// CHS translate: two 8-step serial multiplies.
// Set geometry: 8-step multiply, then 28-step serial divide.
// One command at a time; a finished beat waits in the output register.
// Reset: address 0/0/1 CHS mode, geometry and capacity to their defaults.
`default_nettype none
module ata_chs_lba_sector_addresser (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         cfg_we,
	input  wire  [1:0]  cfg_index,
	input  wire  [27:0] cfg_data,
	input  wire         cmd_valid,
	output logic        cmd_ready,
	input  wire  [2:0]  operation,
	input  wire         lba_select,
	input  wire  [15:0] cylinder_in,
	input  wire  [3:0]  head_in,
	input  wire  [7:0]  sector_in,
	input  wire  [7:0]  count_in,
	output logic        rsp_valid,
	input  wire         rsp_ready,
	output logic [27:0] linear_sector,
	output logic [15:0] cylinder_out,
	output logic [3:0]  head_out,
	output logic [7:0]  sector_out,
	output logic [15:0] geometry_cylinders,
	output logic [1:0]  fault
);

	atachs_pkg::state_t state_q, state_d;

	logic [atachs_pkg::ADDR_W-1:0]  cap_q;
	logic [atachs_pkg::CYL_W-1:0]   cyl_q;
	logic [atachs_pkg::HEAD_W-1:0]  head_q;
	logic [atachs_pkg::SECT_W-1:0]  sec_q;
	logic                           lba_q;
	logic [atachs_pkg::CYL_W-1:0]   gcyl_q;
	logic [atachs_pkg::GHEAD_W-1:0] gheads_q;
	logic [atachs_pkg::SECT_W-1:0]  gsec_q;
	logic [atachs_pkg::ADDR_W-1:0]  lin_q;
	atachs_pkg::fault_t             fault_q;
	logic                           rsp_valid_q;

	atachs_pkg::md_req_t md_req;
	atachs_pkg::md_rsp_t md_rsp;

	logic                           accept;
	logic                           can_load;
	logic                           finish;
	logic [atachs_pkg::ADDR_W-1:0]  packed_a;
	logic [atachs_pkg::ADDR_W-1:0]  lba_pos;
	logic [atachs_pkg::ADDR_W-1:0]  a_inc;
	logic [atachs_pkg::ADDR_W-1:0]  a_next;
	logic                           chs_bad;
	logic [atachs_pkg::GHEAD_W-1:0] nh;
	logic [atachs_pkg::GHEAD_W-1:0] head_p1;

	atachs_muldiv u_muldiv (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (md_req),
		.rsp    (md_rsp)
	);

	assign can_load  = !rsp_valid_q || rsp_ready;
	assign cmd_ready = (state_q == atachs_pkg::ST_IDLE) && can_load;
	assign accept    = cmd_valid && cmd_ready;
	assign finish    = (accept && state_d == atachs_pkg::ST_IDLE) ||
	                   (state_q != atachs_pkg::ST_IDLE && state_d == atachs_pkg::ST_IDLE);

	assign packed_a = {head_q, cyl_q, sec_q};
	assign lba_pos  = packed_a & atachs_pkg::LBA_MASK;
	assign a_inc    = packed_a + 1'b1;
	assign a_next   = (packed_a & ~atachs_pkg::LBA_MASK) | (a_inc & atachs_pkg::LBA_MASK);
	assign chs_bad  = (cyl_q >= gcyl_q) || ({1'b0, head_q} >= gheads_q) ||
	                  (sec_q == '0) || (sec_q > gsec_q);
	assign nh       = {1'b0, head_q} + 1'b1;
	assign head_p1  = {1'b0, head_in} + 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= atachs_pkg::ST_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d       = state_q;
		md_req.start  = 1'b0;
		md_req.op     = atachs_pkg::MD_MUL;
		md_req.a      = '0;
		md_req.addend = '0;
		md_req.b      = '0;
		case (state_q)
			atachs_pkg::ST_IDLE: begin
				if (accept) begin
					if (operation == atachs_pkg::OP_TRANSLATE && !lba_q && !chs_bad) begin
						md_req.start  = 1'b1;
						md_req.a      = atachs_pkg::MD_W'(cyl_q);
						md_req.b      = atachs_pkg::DVS_W'(gheads_q);
						md_req.addend = atachs_pkg::MD_W'(head_q);
						state_d       = atachs_pkg::ST_MUL_HEADS;
					end else if (operation == atachs_pkg::OP_SET_GEOM && count_in != '0) begin
						md_req.start = 1'b1;
						md_req.a     = atachs_pkg::MD_W'(count_in);
						md_req.b     = atachs_pkg::DVS_W'(head_p1);
						state_d      = atachs_pkg::ST_MUL_DIVISOR;
					end
				end
			end
			atachs_pkg::ST_MUL_HEADS: begin
				if (md_rsp.done) begin
					md_req.start  = 1'b1;
					md_req.a      = md_rsp.result;
					md_req.b      = atachs_pkg::DVS_W'(gsec_q);
					md_req.addend = atachs_pkg::MD_W'(sec_q - 1'b1);
					state_d       = atachs_pkg::ST_MUL_SECTS;
				end
			end
			atachs_pkg::ST_MUL_DIVISOR: begin
				if (md_rsp.done) begin
					md_req.start = 1'b1;
					md_req.op    = atachs_pkg::MD_DIV;
					md_req.a     = atachs_pkg::MD_W'(cap_q);
					md_req.b     = md_rsp.result[atachs_pkg::DVS_W-1:0];
					state_d      = atachs_pkg::ST_DIV;
				end
			end
			atachs_pkg::ST_MUL_SECTS, atachs_pkg::ST_DIV: begin
				if (md_rsp.done && can_load)
					state_d = atachs_pkg::ST_IDLE;
			end
			default: state_d = atachs_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			rsp_valid_q <= 1'b0;
		else if (finish)
			rsp_valid_q <= 1'b1;
		else if (rsp_ready)
			rsp_valid_q <= 1'b0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q    <= atachs_pkg::RST_CAPACITY;
			cyl_q    <= '0;
			head_q   <= '0;
			sec_q    <= atachs_pkg::SECT_W'(1);
			lba_q    <= 1'b0;
			gcyl_q   <= atachs_pkg::RST_CYLS;
			gheads_q <= atachs_pkg::RST_HEADS;
			gsec_q   <= atachs_pkg::RST_SECTS;
			lin_q    <= '0;
			fault_q  <= atachs_pkg::FAULT_NONE;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					atachs_pkg::CFG_CAPACITY: cap_q    <= cfg_data;
					atachs_pkg::CFG_CYLS:     gcyl_q   <= cfg_data[atachs_pkg::CYL_W-1:0];
					atachs_pkg::CFG_HEADS:    gheads_q <= cfg_data[atachs_pkg::GHEAD_W-1:0];
					atachs_pkg::CFG_SECTS:    gsec_q   <= cfg_data[atachs_pkg::SECT_W-1:0];
					default: ;
				endcase
			end
			if (accept) begin
				lin_q   <= '0;
				fault_q <= atachs_pkg::FAULT_NONE;
				case (operation)
					atachs_pkg::OP_LOAD: begin
						lba_q  <= lba_select;
						cyl_q  <= cylinder_in;
						head_q <= head_in;
						sec_q  <= sector_in;
					end
					atachs_pkg::OP_TRANSLATE: begin
						if (lba_q) begin
							if (lba_pos >= cap_q)
								fault_q <= atachs_pkg::FAULT_RANGE;
							else
								lin_q <= lba_pos;
						end else if (chs_bad) begin
							fault_q <= atachs_pkg::FAULT_RANGE;
						end
					end
					atachs_pkg::OP_ADVANCE: begin
						if (lba_q) begin
							sec_q  <= a_next[7:0];
							cyl_q  <= a_next[23:8];
							head_q <= a_next[27:24];
						end else if (sec_q < gsec_q) begin
							sec_q <= sec_q + 1'b1;
						end else begin
							sec_q <= atachs_pkg::SECT_W'(1);
							if (nh < gheads_q && !nh[atachs_pkg::HEAD_W]) begin
								head_q <= nh[atachs_pkg::HEAD_W-1:0];
							end else begin
								head_q <= '0;
								cyl_q  <= cyl_q + 1'b1;
							end
						end
					end
					atachs_pkg::OP_RECAL: begin
						cyl_q  <= '0;
						head_q <= '0;
						sec_q  <= atachs_pkg::SECT_W'(!lba_q);
					end
					atachs_pkg::OP_SET_GEOM: begin
						gheads_q <= head_p1;
						gsec_q   <= count_in;
						if (count_in == '0)
							fault_q <= atachs_pkg::FAULT_ZERO;
					end
					default: ;
				endcase
			end
			if (md_rsp.done && can_load) begin
				if (state_q == atachs_pkg::ST_MUL_SECTS) begin
					if (md_rsp.result >= atachs_pkg::MD_W'(cap_q)) begin
						lin_q   <= '0;
						fault_q <= atachs_pkg::FAULT_RANGE;
					end else begin
						lin_q   <= md_rsp.result[atachs_pkg::ADDR_W-1:0];
						fault_q <= atachs_pkg::FAULT_NONE;
					end
				end else if (state_q == atachs_pkg::ST_DIV) begin
					gcyl_q  <= (|md_rsp.result[atachs_pkg::MD_W-1:atachs_pkg::CYL_W]) ?
					           '1 : md_rsp.result[atachs_pkg::CYL_W-1:0];
					lin_q   <= '0;
					fault_q <= atachs_pkg::FAULT_NONE;
				end
			end
		end
	end

	assign rsp_valid          = rsp_valid_q;
	assign linear_sector      = lin_q;
	assign cylinder_out       = cyl_q;
	assign head_out           = head_q;
	assign sector_out         = sec_q;
	assign geometry_cylinders = gcyl_q;
	assign fault              = fault_q;

endmodule
`default_nettype wire
